[rtl/bdl_pkg.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer package
// Shared widths, lexer mode codes, character codes and the report type.
// ----------------------------------------------------------------------------
`default_nettype none

package bdl_pkg;

  // Counter widths.
  localparam int DEPTH_WIDTH = 16;
  localparam int LINE_WIDTH  = 32;

  // Saturation bounds of the signed depth counter.
  localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
  localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};

  // Report queue depth between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Lexer mode codes.
  localparam logic [3:0] M_NORMAL    = 4'd0;
  localparam logic [3:0] M_SLASH     = 4'd1;
  localparam logic [3:0] M_R         = 4'd2;
  localparam logic [3:0] M_RQUOTE    = 4'd3;
  localparam logic [3:0] M_LINECMT   = 4'd4;
  localparam logic [3:0] M_BLOCK     = 4'd5;
  localparam logic [3:0] M_BLOCKSTAR = 4'd6;
  localparam logic [3:0] M_RAW       = 4'd7;
  localparam logic [3:0] M_RAWPAREN  = 4'd8;
  localparam logic [3:0] M_STR       = 4'd9;
  localparam logic [3:0] M_STRESC    = 4'd10;
  localparam logic [3:0] M_CHR       = 4'd11;
  localparam logic [3:0] M_CHRESC    = 4'd12;

  // ASCII codes the lexer looks for.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_UPPER_R   = 8'h52;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;

  // Report kinds.
  localparam logic KIND_ZERO  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // One queued entry: up to two reports sharing line and depth.
  typedef struct packed {
    logic                          has_zero;
    logic                          has_final;
    logic [LINE_WIDTH-1:0]         line;
    logic signed [DEPTH_WIDTH-1:0] depth;
  } report_t;

endpackage

`default_nettype wire

[rtl/bdl_front.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer front: keeps depth and line counts, queues reports.
// Lexes one byte per cycle while the report queue has space.
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  wire  [7:0]            byte_i,
  input  wire                   last_i,
  input  wire                   space_i,
  output logic                  push_o,
  output bdl_pkg::report_t      entry_o
);

  logic [3:0]                             mode_q, mode_d;
  logic signed [bdl_pkg::DEPTH_WIDTH-1:0] depth_q, depth_d;
  logic [bdl_pkg::LINE_WIDTH-1:0]         line_q, line_d;
  logic [3:0]                             base_mode;
  logic                                   resolved;
  logic                                   open_br, close_br;
  logic                                   hit_zero;
  logic                                   fire;

  assign ready_o = space_i;
  assign fire    = valid_i && space_i;

  // Resolve pending prefix modes, then lex the byte in the base mode.
  always_comb begin
    mode_d    = mode_q;
    base_mode = mode_q;
    resolved  = 1'b0;
    open_br   = 1'b0;
    close_br  = 1'b0;
    case (mode_q)
      bdl_pkg::M_SLASH: begin
        if (byte_i == bdl_pkg::CH_SLASH) begin
          mode_d = bdl_pkg::M_LINECMT; resolved = 1'b1;
        end else if (byte_i == bdl_pkg::CH_STAR) begin
          mode_d = bdl_pkg::M_BLOCK; resolved = 1'b1;
        end else begin
          base_mode = bdl_pkg::M_NORMAL;
        end
      end
      bdl_pkg::M_R: begin
        if (byte_i == bdl_pkg::CH_DQUOTE) begin
          mode_d = bdl_pkg::M_RQUOTE; resolved = 1'b1;
        end else begin
          base_mode = bdl_pkg::M_NORMAL;
        end
      end
      bdl_pkg::M_RQUOTE: begin
        if (byte_i == bdl_pkg::CH_LPAREN) begin
          mode_d = bdl_pkg::M_RAW; resolved = 1'b1;
        end else begin
          base_mode = bdl_pkg::M_STR;
        end
      end
      bdl_pkg::M_BLOCKSTAR: begin
        if (byte_i == bdl_pkg::CH_SLASH) begin
          mode_d = bdl_pkg::M_NORMAL; resolved = 1'b1;
        end else begin
          base_mode = bdl_pkg::M_BLOCK;
        end
      end
      bdl_pkg::M_RAWPAREN: begin
        if (byte_i == bdl_pkg::CH_DQUOTE) begin
          mode_d = bdl_pkg::M_NORMAL; resolved = 1'b1;
        end else begin
          base_mode = bdl_pkg::M_RAW;
        end
      end
      bdl_pkg::M_LINECMT: begin
        mode_d   = (byte_i == bdl_pkg::CH_NEWLINE) ? bdl_pkg::M_NORMAL : bdl_pkg::M_LINECMT;
        resolved = 1'b1;
      end
      bdl_pkg::M_STRESC: begin
        mode_d = bdl_pkg::M_STR; resolved = 1'b1;
      end
      bdl_pkg::M_CHR: begin
        if (byte_i == bdl_pkg::CH_BACKSLASH) begin
          mode_d = bdl_pkg::M_CHRESC;
        end else if (byte_i == bdl_pkg::CH_SQUOTE) begin
          mode_d = bdl_pkg::M_NORMAL;
        end else begin
          mode_d = bdl_pkg::M_CHR;
        end
        resolved = 1'b1;
      end
      bdl_pkg::M_CHRESC: begin
        mode_d = bdl_pkg::M_CHR; resolved = 1'b1;
      end
      bdl_pkg::M_NORMAL, bdl_pkg::M_STR, bdl_pkg::M_BLOCK, bdl_pkg::M_RAW: begin
        base_mode = mode_q;
      end
      default: begin
        base_mode = bdl_pkg::M_NORMAL;
      end
    endcase

    if (!resolved) begin
      case (base_mode)
        bdl_pkg::M_STR: begin
          if (byte_i == bdl_pkg::CH_BACKSLASH) begin
            mode_d = bdl_pkg::M_STRESC;
          end else if (byte_i == bdl_pkg::CH_DQUOTE) begin
            mode_d = bdl_pkg::M_NORMAL;
          end else begin
            mode_d = bdl_pkg::M_STR;
          end
        end
        bdl_pkg::M_BLOCK: begin
          mode_d = (byte_i == bdl_pkg::CH_STAR) ? bdl_pkg::M_BLOCKSTAR : bdl_pkg::M_BLOCK;
        end
        bdl_pkg::M_RAW: begin
          mode_d = (byte_i == bdl_pkg::CH_RPAREN) ? bdl_pkg::M_RAWPAREN : bdl_pkg::M_RAW;
        end
        default: begin
          // Normal code.
          if (byte_i == bdl_pkg::CH_SLASH) begin
            mode_d = bdl_pkg::M_SLASH;
          end else if (byte_i == bdl_pkg::CH_UPPER_R) begin
            mode_d = bdl_pkg::M_R;
          end else if (byte_i == bdl_pkg::CH_DQUOTE) begin
            mode_d = bdl_pkg::M_STR;
          end else if (byte_i == bdl_pkg::CH_SQUOTE) begin
            mode_d = bdl_pkg::M_CHR;
          end else begin
            mode_d   = bdl_pkg::M_NORMAL;
            open_br  = (byte_i == bdl_pkg::CH_LBRACE);
            close_br = (byte_i == bdl_pkg::CH_RBRACE);
          end
        end
      endcase
    end
  end

  // Saturating depth and line counters.
  always_comb begin
    depth_d  = depth_q;
    hit_zero = 1'b0;
    if (open_br && (depth_q != bdl_pkg::DEPTH_MAX)) begin
      depth_d = depth_q + 1'b1;
    end else if (close_br && (depth_q != bdl_pkg::DEPTH_MIN)) begin
      depth_d  = depth_q - 1'b1;
      hit_zero = (depth_q == bdl_pkg::DEPTH_WIDTH'(1));
    end
    line_d = line_q;
    if ((byte_i == bdl_pkg::CH_NEWLINE) && (line_q != bdl_pkg::LINE_MAX)) begin
      line_d = line_q + 1'b1;
    end
  end

  // Report entry for this byte.
  always_comb begin
    entry_o.has_zero  = hit_zero;
    entry_o.has_final = last_i;
    entry_o.line      = line_q;
    entry_o.depth     = depth_d;
    push_o            = fire && (hit_zero || last_i);
  end

  // State registers; the final byte returns everything to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= bdl_pkg::M_NORMAL;
      depth_q <= '0;
      line_q  <= bdl_pkg::LINE_WIDTH'(1);
    end else if (fire) begin
      if (last_i) begin
        mode_q  <= bdl_pkg::M_NORMAL;
        depth_q <= '0;
        line_q  <= bdl_pkg::LINE_WIDTH'(1);
      end else begin
        mode_q  <= mode_d;
        depth_q <= depth_d;
        line_q  <= line_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bdl_queue.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer report queue
// Small register FIFO that decouples the lexer front from the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  bdl_pkg::report_t      entry_i,
  output logic                  space_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output bdl_pkg::report_t      entry_o
);

  bdl_pkg::report_t               mem_q [bdl_pkg::QDEPTH];
  logic [bdl_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [bdl_pkg::QCNT_W-1:0]     count_q;

  assign space_o = (count_q != bdl_pkg::QCNT_W'(bdl_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == bdl_pkg::QPTR_W'(bdl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == bdl_pkg::QPTR_W'(bdl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bdl_back.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer back
// Output register that unpacks queued entries into one or two reports.
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  input  bdl_pkg::report_t      q_entry_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  wire                   ready_i,
  output logic                  kind_o,
  output logic                  last_o,
  output logic [31:0]           line_o,
  output logic [15:0]           depth_o
);

  logic             valid_q;
  logic             second_q;
  bdl_pkg::report_t entry_q;
  logic             show_zero;
  logic             take;
  logic             done;

  // Current report: the zero report comes first when both are present.
  assign show_zero = entry_q.has_zero && !second_q;
  assign kind_o    = show_zero ? bdl_pkg::KIND_ZERO : bdl_pkg::KIND_FINAL;
  assign last_o    = show_zero ? !entry_q.has_final : 1'b1;
  assign line_o    = 32'(entry_q.line);
  assign depth_o   = 16'(entry_q.depth);
  assign valid_o   = valid_q;

  assign take  = valid_q && ready_i;
  assign done  = take && last_o;
  assign pop_o = q_valid_i && (!valid_q || done);

  // Output register and second-report flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q  <= 1'b1;
        second_q <= 1'b0;
      end else if (done) begin
        valid_q  <= 1'b0;
        second_q <= 1'b0;
      end else if (take) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= q_entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/brace_depth_lexer_top.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer top level
// Tracks brace depth of C++ source text and reports depth-zero and end events.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes arrive on the s_axis channel, one byte per request, with
//   tlast marking the final byte of a text. Comments, string and char
//   literals and plain raw strings are skipped; braces elsewhere move a
//   saturating signed depth. Reports leave on the m_axis channel: tuser is
//   the kind (zero reached or final depth), tdata carries line and depth,
//   and tlast marks the last report caused by one input byte.
//   The lexer takes one byte every cycle while the report queue has space;
//   its mode and counters update with each accepted byte. A report passes
//   through the report queue and then the back's output register before
//   tvalid rises. A byte causing both reports leaves as two transfers,
//   which the two-entry report queue absorbs. When the receiver stalls the
//   queue fills and s_axis_tready drops only once it is full.
//   Reset puts the lexer in normal code mode with depth zero and line one;
//   the same happens after every byte marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module brace_depth_lexer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] line_number, [47:32] brace_depth
  output logic        m_axis_tuser,   // [0] report_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic             space;
  logic             push;
  logic             pop;
  logic             q_valid;
  bdl_pkg::report_t push_entry;
  bdl_pkg::report_t q_entry;
  logic [31:0]      line_num;
  logic [15:0]      depth_val;

  bdl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .space_i (space),
    .push_o  (push),
    .entry_o (push_entry)
  );

  bdl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  bdl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .kind_o    (m_axis_tuser),
    .last_o    (m_axis_tlast),
    .line_o    (line_num),
    .depth_o   (depth_val)
  );

  assign m_axis_tdata = {depth_val, line_num};

  // A final-depth report always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == bdl_pkg::KIND_FINAL)) |-> m_axis_tlast)
    else $error("final report without tlast");

  // A zero report carries depth zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == bdl_pkg::KIND_ZERO)) |-> (m_axis_tdata[47:32] == 16'd0))
    else $error("zero report with nonzero depth");

  // A zero report that does not close its run is followed by the final report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && (m_axis_tuser == bdl_pkg::KIND_ZERO) && !m_axis_tlast)
    |=> (m_axis_tvalid && (m_axis_tuser == bdl_pkg::KIND_FINAL)))
    else $error("missing final report after zero report");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from empty report queue");

endmodule

`default_nettype wire

[test/brace_depth_lexer_top_test.sv]
// ----------------------------------------------------------------------------
// Brace depth lexer testbench
// Streams C++-like source text into the lexer and checks every report it
// emits against a hand-written report or a cycle-free model of the lexer
// modes and the saturating depth and line counters. A short table of
// directed bytes comes first, then random token streams. Both stream sides
// idle at random, except for one stretch of the random part.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module brace_depth_lexer_top_test;

  // One report as it leaves the block.
  typedef struct packed {
    logic                                   kind;
    logic [bdl_pkg::LINE_WIDTH-1:0]         line;
    logic signed [bdl_pkg::DEPTH_WIDTH-1:0] depth;
    logic                                   run_last;
  } depth_report_t;

  // One source byte request, with an optional hand-written expected report.
  typedef struct packed {
    logic [7:0]    data;
    logic          eot;
    logic          fixed;
    depth_report_t want;
  } source_byte_t;

  localparam int DIRECTED_ROWS = 27;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Disables idling on both sides while set.
  logic calm = 1'b0;

  // Model state of the lexer.
  logic [3:0]                             trk_mode;
  logic signed [bdl_pkg::DEPTH_WIDTH-1:0] trk_depth;
  logic [bdl_pkg::LINE_WIDTH-1:0]         trk_line;
  depth_report_t                          trk_out [2];
  int                                     trk_n;

  depth_report_t pending_reports [$];
  source_byte_t  directed_tab [DIRECTED_ROWS];
  source_byte_t  source_text [$];
  source_byte_t  drv_item;

  int unsigned err_count   = 0;
  int unsigned bytes_in    = 0;
  int unsigned zero_seen   = 0;
  int unsigned final_seen  = 0;

  brace_depth_lexer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] line_number, [47:32] brace_depth
    .m_axis_tuser  (m_axis_tuser),   // [0] report_kind
    .m_axis_tlast  (m_axis_tlast)    // last_of_run
  );

  always #4 clk_i = ~clk_i;

  // Table rows: a plain byte, or a byte with its single report written out.
  function automatic source_byte_t plain_row(input logic [7:0] c, input logic eot);
    source_byte_t r;
    r       = '0;
    r.data  = c;
    r.eot   = eot;
    return r;
  endfunction

  function automatic source_byte_t fixed_row(input logic [7:0] c, input logic eot,
                                             input logic kind, input logic [31:0] line,
                                             input logic signed [15:0] depth,
                                             input logic run_last);
    source_byte_t r;
    r       = plain_row(c, eot);
    r.fixed = 1'b1;
    r.want  = '{kind: kind, line: line, depth: depth, run_last: run_last};
    return r;
  endfunction

  // Advances the lexer mode by one byte; returns +1 for an opening brace in
  // code, -1 for a closing one, else 0. An unfinished prefix falls through
  // to the mode it degrades to and lexes the byte again there.
  function automatic int lex_step(input logic [7:0] c);
    logic [3:0] m;
    int         step;
    bit         done;
    m    = trk_mode;
    step = 0;
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      case (m)
        bdl_pkg::M_NORMAL: begin
          if (c == bdl_pkg::CH_SLASH) trk_mode = bdl_pkg::M_SLASH;
          else if (c == bdl_pkg::CH_UPPER_R) trk_mode = bdl_pkg::M_R;
          else if (c == bdl_pkg::CH_DQUOTE) trk_mode = bdl_pkg::M_STR;
          else if (c == bdl_pkg::CH_SQUOTE) trk_mode = bdl_pkg::M_CHR;
          else begin
            trk_mode = bdl_pkg::M_NORMAL;
            if (c == bdl_pkg::CH_LBRACE) step = 1;
            else if (c == bdl_pkg::CH_RBRACE) step = -1;
          end
        end
        bdl_pkg::M_SLASH: begin
          if (c == bdl_pkg::CH_SLASH) trk_mode = bdl_pkg::M_LINECMT;
          else if (c == bdl_pkg::CH_STAR) trk_mode = bdl_pkg::M_BLOCK;
          else begin
            m    = bdl_pkg::M_NORMAL;
            done = 1'b0;
          end
        end
        bdl_pkg::M_R: begin
          if (c == bdl_pkg::CH_DQUOTE) trk_mode = bdl_pkg::M_RQUOTE;
          else begin
            m    = bdl_pkg::M_NORMAL;
            done = 1'b0;
          end
        end
        bdl_pkg::M_RQUOTE: begin
          if (c == bdl_pkg::CH_LPAREN) trk_mode = bdl_pkg::M_RAW;
          else begin
            m    = bdl_pkg::M_STR;
            done = 1'b0;
          end
        end
        bdl_pkg::M_LINECMT: begin
          if (c == bdl_pkg::CH_NEWLINE) trk_mode = bdl_pkg::M_NORMAL;
          else trk_mode = bdl_pkg::M_LINECMT;
        end
        bdl_pkg::M_BLOCK: begin
          if (c == bdl_pkg::CH_STAR) trk_mode = bdl_pkg::M_BLOCKSTAR;
          else trk_mode = bdl_pkg::M_BLOCK;
        end
        bdl_pkg::M_BLOCKSTAR: begin
          if (c == bdl_pkg::CH_SLASH) trk_mode = bdl_pkg::M_NORMAL;
          else begin
            m    = bdl_pkg::M_BLOCK;
            done = 1'b0;
          end
        end
        bdl_pkg::M_RAW: begin
          if (c == bdl_pkg::CH_RPAREN) trk_mode = bdl_pkg::M_RAWPAREN;
          else trk_mode = bdl_pkg::M_RAW;
        end
        bdl_pkg::M_RAWPAREN: begin
          if (c == bdl_pkg::CH_DQUOTE) trk_mode = bdl_pkg::M_NORMAL;
          else begin
            m    = bdl_pkg::M_RAW;
            done = 1'b0;
          end
        end
        bdl_pkg::M_STR: begin
          if (c == bdl_pkg::CH_BACKSLASH) trk_mode = bdl_pkg::M_STRESC;
          else if (c == bdl_pkg::CH_DQUOTE) trk_mode = bdl_pkg::M_NORMAL;
          else trk_mode = bdl_pkg::M_STR;
        end
        bdl_pkg::M_STRESC:    trk_mode = bdl_pkg::M_STR;
        bdl_pkg::M_CHR: begin
          if (c == bdl_pkg::CH_BACKSLASH) trk_mode = bdl_pkg::M_CHRESC;
          else if (c == bdl_pkg::CH_SQUOTE) trk_mode = bdl_pkg::M_NORMAL;
          else trk_mode = bdl_pkg::M_CHR;
        end
        bdl_pkg::M_CHRESC:    trk_mode = bdl_pkg::M_CHR;
        default: begin
          m    = bdl_pkg::M_NORMAL;
          done = 1'b0;
        end
      endcase
    end
    return step;
  endfunction

  // Computes the reports caused by one source byte into trk_out / trk_n.
  task automatic track_byte(input logic [7:0] c, input logic eot);
    logic [bdl_pkg::LINE_WIDTH-1:0] line_here;
    bit                             hit_zero;
    int                             step;
    line_here = trk_line;
    hit_zero  = 1'b0;
    trk_n     = 0;
    step      = lex_step(c);
    if (step > 0) begin
      if (trk_depth != bdl_pkg::DEPTH_MAX) trk_depth = trk_depth + 1'b1;
    end else if (step < 0) begin
      // A closing brace at the lower bound is absorbed and gives no zero report.
      if (trk_depth != bdl_pkg::DEPTH_MIN) begin
        trk_depth = trk_depth - 1'b1;
        hit_zero  = (trk_depth == 0);
      end
    end
    if (c == bdl_pkg::CH_NEWLINE && trk_line != bdl_pkg::LINE_MAX) trk_line = trk_line + 1'b1;
    if (hit_zero) begin
      trk_out[trk_n] = '{kind: bdl_pkg::KIND_ZERO, line: line_here, depth: trk_depth,
                         run_last: !eot};
      trk_n++;
    end
    if (eot) begin
      trk_out[trk_n] = '{kind: bdl_pkg::KIND_FINAL, line: line_here, depth: trk_depth,
                         run_last: 1'b1};
      trk_n++;
      trk_mode  = bdl_pkg::M_NORMAL;
      trk_depth = '0;
      trk_line  = bdl_pkg::LINE_WIDTH'(1);
    end
  endtask

  // Random text generation.
  task automatic put(input logic [7:0] c);
    source_text.push_back(plain_row(c, 1'b0));
  endtask

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0:       c = bdl_pkg::CH_LBRACE;
      1:       c = bdl_pkg::CH_RBRACE;
      2:       c = bdl_pkg::CH_LPAREN;
      3:       c = bdl_pkg::CH_RPAREN;
      4:       c = bdl_pkg::CH_STAR;
      5:       c = bdl_pkg::CH_SLASH;
      6:       c = bdl_pkg::CH_BACKSLASH;
      7:       c = bdl_pkg::CH_DQUOTE;
      8:       c = bdl_pkg::CH_SQUOTE;
      9:       c = bdl_pkg::CH_NEWLINE;
      10:      c = bdl_pkg::CH_UPPER_R;
      default: c = 8'($urandom_range(32, 126));
    endcase
    return c;
  endfunction

  // A byte that never completes a '/', 'R' or R" prefix.
  function automatic logic [7:0] pick_follow();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = bdl_pkg::CH_LBRACE;
      1:       c = bdl_pkg::CH_RBRACE;
      2:       c = bdl_pkg::CH_NEWLINE;
      default: c = "a";
    endcase
    return c;
  endfunction

  // Body of a literal or comment that stop would end; inside quotes a
  // backslash escapes the next byte, which may then be anything.
  task automatic put_body(input logic [7:0] stop, input int n);
    logic [7:0] c;
    repeat (n) begin
      c = pick_text_char();
      if (c == stop) c = "x";
      if (c == bdl_pkg::CH_BACKSLASH &&
          (stop == bdl_pkg::CH_DQUOTE || stop == bdl_pkg::CH_SQUOTE)) begin
        put(c);
        c = pick_text_char();
      end
      put(c);
    end
  endtask

  task automatic add_token();
    int         n;
    logic [7:0] noise;
    n     = $urandom_range(0, 6);
    noise = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: put(bdl_pkg::CH_LBRACE);
      5, 6, 7, 8:    put(bdl_pkg::CH_RBRACE);
      9, 10:         put(bdl_pkg::CH_NEWLINE);
      11: begin
        put(bdl_pkg::CH_SLASH);
        put(bdl_pkg::CH_SLASH);
        put_body(bdl_pkg::CH_NEWLINE, n);
        put(bdl_pkg::CH_NEWLINE);
      end
      12: begin
        put(bdl_pkg::CH_SLASH);
        put(bdl_pkg::CH_STAR);
        put_body(bdl_pkg::CH_STAR, n);
        // A star that does not close the comment.
        if ($urandom_range(0, 2) == 0) begin
          put(bdl_pkg::CH_STAR);
          put(bdl_pkg::CH_RBRACE);
        end
        put(bdl_pkg::CH_STAR);
        put(bdl_pkg::CH_SLASH);
      end
      13: begin
        put(bdl_pkg::CH_DQUOTE);
        put_body(bdl_pkg::CH_DQUOTE, n);
        put(bdl_pkg::CH_DQUOTE);
      end
      14: begin
        put(bdl_pkg::CH_SQUOTE);
        put_body(bdl_pkg::CH_SQUOTE, n >> 1);
        put(bdl_pkg::CH_SQUOTE);
      end
      15: begin
        put(bdl_pkg::CH_UPPER_R);
        put(bdl_pkg::CH_DQUOTE);
        put(bdl_pkg::CH_LPAREN);
        put_body(bdl_pkg::CH_RPAREN, n);
        // A closing paren that does not end the raw string.
        if ($urandom_range(0, 2) == 0) begin
          put(bdl_pkg::CH_RPAREN);
          put(bdl_pkg::CH_LBRACE);
        end
        put(bdl_pkg::CH_RPAREN);
        put(bdl_pkg::CH_DQUOTE);
      end
      16, 17: put(noise);
      18: begin
        case ($urandom_range(0, 2))
          0: begin
            put(bdl_pkg::CH_SLASH);
            put(pick_follow());
          end
          1: begin
            put(bdl_pkg::CH_UPPER_R);
            put(pick_follow());
          end
          default: begin
            // R" without the paren opens an ordinary string.
            put(bdl_pkg::CH_UPPER_R);
            put(bdl_pkg::CH_DQUOTE);
            put(pick_follow());
            put_body(bdl_pkg::CH_DQUOTE, n);
            put(bdl_pkg::CH_DQUOTE);
          end
        endcase
      end
      default: put(" ");
    endcase
    if ($urandom_range(0, 39) == 0) source_text[$].eot = 1'b1;
  endtask

  // Drives one source byte after a random gap and waits for its request.
  task automatic send_byte(input source_byte_t item);
    while (!calm && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    drv_item = item;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item.data;
    s_axis_tlast  <= item.eot;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Receiver side idling.
  always @(negedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
  end

  // Predicts on every accepted byte and checks every accepted report.
  always @(posedge clk_i) begin : monitor
    depth_report_t got;
    depth_report_t w;
    if (!rst_ni) begin
      trk_mode  = bdl_pkg::M_NORMAL;
      trk_depth = '0;
      trk_line  = bdl_pkg::LINE_WIDTH'(1);
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_in++;
        track_byte(s_axis_tdata, s_axis_tlast);
        if (drv_item.fixed) pending_reports.push_back(drv_item.want);
        else for (int k = 0; k < trk_n; k++) pending_reports.push_back(trk_out[k]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tuser, line: m_axis_tdata[31:0],
                depth: m_axis_tdata[47:32], run_last: m_axis_tlast};
        if (got.kind == bdl_pkg::KIND_ZERO) zero_seen++;
        else final_seen++;
        if (pending_reports.size() == 0) begin
          if (err_count < 10)
            $display("%0t: report with none expected: kind %0d line %0d depth %0d last %0d",
                     $time, got.kind, got.line, got.depth, got.run_last);
          err_count++;
        end else begin
          w = pending_reports.pop_front();
          if (got.kind !== w.kind || got.line !== w.line || got.depth !== w.depth ||
              got.run_last !== w.run_last) begin
            if (err_count < 10)
              $display("%0t: mismatch: exp k%0d l%0d d%0d t%0d, got k%0d l%0d d%0d t%0d",
                       $time, w.kind, w.line, w.depth, w.run_last,
                       got.kind, got.line, got.depth, got.run_last);
            err_count++;
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int unsigned calm_lo;
    int unsigned calm_hi;

    directed_tab = '{
      // A lone final byte right after reset, then a final brace going negative.
      fixed_row(8'hFF, 1'b1, bdl_pkg::KIND_FINAL, 32'd1, 16'sd0, 1'b1),
      fixed_row(bdl_pkg::CH_RBRACE, 1'b1, bdl_pkg::KIND_FINAL, 32'd1, -16'sd1, 1'b1),
      plain_row(bdl_pkg::CH_LBRACE, 1'b0),
      fixed_row(bdl_pkg::CH_RBRACE, 1'b0, bdl_pkg::KIND_ZERO, 32'd1, 16'sd0, 1'b1),
      plain_row(bdl_pkg::CH_NEWLINE, 1'b0),
      // Line comment hides a brace until the newline.
      plain_row(bdl_pkg::CH_SLASH, 1'b0),
      plain_row(bdl_pkg::CH_SLASH, 1'b0),
      plain_row(bdl_pkg::CH_RBRACE, 1'b0),
      plain_row(bdl_pkg::CH_NEWLINE, 1'b0),
      // Block comment: the opener star cannot close it.
      plain_row(bdl_pkg::CH_SLASH, 1'b0),
      plain_row(bdl_pkg::CH_STAR, 1'b0),
      plain_row(bdl_pkg::CH_SLASH, 1'b0),
      plain_row(bdl_pkg::CH_STAR, 1'b0),
      plain_row(bdl_pkg::CH_SLASH, 1'b0),
      // Raw string with a brace inside.
      plain_row(bdl_pkg::CH_UPPER_R, 1'b0),
      plain_row(bdl_pkg::CH_DQUOTE, 1'b0),
      plain_row(bdl_pkg::CH_LPAREN, 1'b0),
      plain_row(bdl_pkg::CH_RBRACE, 1'b0),
      plain_row(bdl_pkg::CH_RPAREN, 1'b0),
      plain_row(bdl_pkg::CH_DQUOTE, 1'b0),
      // An R that starts nothing, so the brace after it counts.
      plain_row(bdl_pkg::CH_UPPER_R, 1'b0),
      plain_row(bdl_pkg::CH_LBRACE, 1'b0),
      // String with an escaped quote.
      plain_row(bdl_pkg::CH_DQUOTE, 1'b0),
      plain_row(bdl_pkg::CH_BACKSLASH, 1'b0),
      plain_row(bdl_pkg::CH_DQUOTE, 1'b0),
      plain_row(bdl_pkg::CH_DQUOTE, 1'b0),
      // Closing brace on the final byte gives both reports.
      plain_row(bdl_pkg::CH_RBRACE, 1'b1)
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_tab[i]) send_byte(directed_tab[i]);

    // Hold off until the directed reports have all come out.
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);

    // Random texts; a stretch in the middle runs with no idling at all.
    while (source_text.size() < 1120) add_token();
    source_text[$].eot = 1'b1;
    calm_lo = 400;
    calm_hi = 650;

    foreach (source_text[i]) begin
      calm <= (i >= calm_lo && i < calm_hi);
      send_byte(source_text[i]);
    end
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;

    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d source bytes in %0d texts of mixed code, comments and literals.",
             bytes_in, final_seen);
    $display("Checked %0d depth-zero and %0d end-of-text reports; %0d mismatches.",
             zero_seen, final_seen, err_count);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("brace_depth_lexer_top_test: clean");
    end else begin
      $display("brace_depth_lexer_top_test: errors");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin : watchdog
    #24_000_000;
    $display("Timeout with %0d reports still expected.", pending_reports.size());
    $display("brace_depth_lexer_top_test: errors");
    $finish;
  end

endmodule
